/* rtl/text_cell_depth_compositor_unit_defines.svh */
// ----------------------------------------------------------------------------
// text_cell_depth_compositor_unit_defines
// Assertion macros shared by the compositor RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_DEPTH_COMPOSITOR_UNIT_DEFINES_SVH
`define TEXT_CELL_DEPTH_COMPOSITOR_UNIT_DEFINES_SVH

// same-cycle implication
`define TCDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcdc assertion failed");

// next-cycle implication
`define TCDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcdc assertion failed");

`endif

/* rtl/tcdc_pkg.sv */
// ----------------------------------------------------------------------------
// tcdc_pkg
// Shared types and constants of the character cell depth compositor.
// ----------------------------------------------------------------------------
package tcdc_pkg;

  localparam int DEF_MAX_COLUMNS = 256;
  localparam int DEF_MAX_ROWS    = 128;

  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [8:0] RST_SCREEN_WIDTH  = 9'd80;
  localparam logic [7:0] RST_SCREEN_HEIGHT = 8'd25;

  typedef struct packed {
    logic [31:0] prio;
    logic [15:0] color;
    logic [7:0]  glyph;
  } cell_t;

  localparam cell_t BLANK_CELL = '{prio: 32'hFFFF_FFFF, color: 16'h0000, glyph: 8'h20};

  typedef struct packed {
    logic load;
    logic calc;
    logic rd;
    logic finish;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/text_cell_depth_compositor_unit.sv */
// ----------------------------------------------------------------------------
// text_cell_depth_compositor_unit
// Character cell frame store with per-cell depth test.
// Draw/read: the input beat is captured, the cell address computed, the cell
// read, then the result registered once the output slot is free. Clear blanks
// every cell, one per cycle. A new item is taken once the last result is registered.
// Reset (rst_n low, synchronous): 80x25 screen, then a blanking pass over all
// MAX_COLUMNS*MAX_ROWS cells with in_tready low; config writes still taken.
// ----------------------------------------------------------------------------
module text_cell_depth_compositor_unit #(
  parameter int MAX_COLUMNS = tcdc_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tcdc_pkg::DEF_MAX_ROWS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,   // 0 screen_width, 1 screen_height
  input  logic [8:0]   cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,    // kind
  input  logic [103:0] in_tdata,    // row, start_x, char_offset, glyph, color, priority_req
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,   // written, in_range
  output logic [55:0]  out_tdata    // cell_glyph, cell_color, cell_priority
);
  import tcdc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tcdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcdc_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/tcdc_ctrl.sv */
// ----------------------------------------------------------------------------
// tcdc_ctrl
// Sequencer: item accept, address, memory read, commit, and clear sweeps.
// ----------------------------------------------------------------------------
`include "text_cell_depth_compositor_unit_defines.svh"

module tcdc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tcdc_pkg::sts_t sts,
  output tcdc_pkg::cmd_t cmd
);
  import tcdc_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid) state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.is_clear ? S_CLEAR : S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_nxt = S_DONE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TCDC_ASSERT_SAME(a_no_accept_in_sweep, clk, rst_n, in_tready, !cmd.sweep)
  `TCDC_ASSERT_SAME(a_finish_needs_slot, clk, rst_n, cmd.finish, sts.out_free)
  `TCDC_ASSERT_NEXT(a_load_then_addr, clk, rst_n, cmd.load, state_r == S_ADDR)
  `TCDC_ASSERT_NEXT(a_init_end_ready, clk, rst_n, (state_r == S_INIT) && sts.sweep_last,
                    in_tready)

endmodule

/* rtl/tcdc_datapath.sv */
// ----------------------------------------------------------------------------
// tcdc_datapath
// Screen config, cell address, cell memory, depth compare and result register.
// ----------------------------------------------------------------------------
`include "text_cell_depth_compositor_unit_defines.svh"

module tcdc_datapath #(
  parameter int MAX_COLUMNS = tcdc_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tcdc_pkg::DEF_MAX_ROWS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tcdc_pkg::cmd_t cmd,
  output tcdc_pkg::sts_t sts,
  input  logic           cfg_valid,
  input  logic           cfg_index,
  input  logic [8:0]     cfg_data,
  input  logic [1:0]     in_tuser,
  input  logic [103:0]   in_tdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [1:0]     out_tuser,
  output logic [55:0]    out_tdata
);
  import tcdc_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WEW   = $clog2(MAX_COLUMNS + 1);
  localparam int HEW   = $clog2(MAX_ROWS + 1);
  localparam int PW    = 16 + WEW;

  logic [8:0]  screen_width_r;
  logic [7:0]  screen_height_r;

  logic [1:0]  kind_r;
  logic [15:0] row_r;
  logic [15:0] start_x_r;
  logic [11:0] offset_r;
  logic [7:0]  glyph_r;
  logic [15:0] color_r;
  logic [31:0] prio_r;

  logic [AW-1:0] idx_r, idx_nxt;
  logic          hit_r, hit_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  cell_t         rd_r;

  logic          out_valid_r;
  logic          written_r, in_range_r;
  cell_t         out_cell_r;

  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic [16:0]    col_sel;
  logic           row_ok, col_ok, kind_loc;
  logic [PW-1:0]  prod, idx_sum;
  logic           is_draw, is_read, prio_ok, item_we, we;
  logic [AW-1:0]  waddr;
  cell_t          wdata;

  cell_t mem [DEPTH];

  // screen registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= RST_SCREEN_WIDTH;
      screen_height_r <= RST_SCREEN_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  screen_width_r  <= cfg_data;
        CFG_HEIGHT: screen_height_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_tuser;
      row_r     <= in_tdata[15:0];
      start_x_r <= in_tdata[31:16];
      offset_r  <= in_tdata[43:32];
      glyph_r   <= in_tdata[51:44];
      color_r   <= in_tdata[67:52];
      prio_r    <= in_tdata[99:68];
    end
  end

  // saturated screen size and cell location
  always_comb begin
    w_eff    = (32'(screen_width_r) > MAX_COLUMNS) ? WEW'(MAX_COLUMNS) : WEW'(screen_width_r);
    h_eff    = (32'(screen_height_r) > MAX_ROWS) ? HEW'(MAX_ROWS) : HEW'(screen_height_r);
    is_draw  = (kind_r == KIND_DRAW);
    is_read  = (kind_r == KIND_READ);
    kind_loc = is_draw || is_read;
    col_sel  = is_draw ? ({start_x_r[15], start_x_r} + {5'b0, offset_r})
                       : {start_x_r[15], start_x_r};
    row_ok   = !row_r[15] && (32'(row_r[14:0]) < 32'(h_eff));
    col_ok   = !col_sel[16] && (32'(col_sel[15:0]) < 32'(w_eff));
    hit_nxt  = kind_loc && row_ok && col_ok;
    prod     = PW'(row_r[14:0]) * PW'(w_eff);
    idx_sum  = prod + PW'(col_sel[15:0]);
    idx_nxt  = idx_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      idx_r <= idx_nxt;
      hit_r <= hit_nxt;
    end
  end

  // sweep counter
  assign cnt_nxt = cmd.sweep ? (cnt_r + AW'(1)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // cell memory
  always_comb begin
    prio_ok = $signed(rd_r.prio) <= $signed(prio_r);
    item_we = cmd.finish && hit_r && is_draw && prio_ok;
    we      = cmd.sweep || item_we;
    waddr   = cmd.sweep ? cnt_r : idx_r;
    wdata   = cmd.sweep ? BLANK_CELL : cell_t'{prio: prio_r, color: color_r, glyph: glyph_r};
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rd_r <= mem[idx_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      written_r  <= item_we;
      in_range_r <= hit_r;
      out_cell_r <= (hit_r && is_read) ? rd_r : '0;
    end
  end

  assign sts.is_clear   = (kind_r == KIND_CLEAR);
  assign sts.sweep_last = (cnt_r == AW'(DEPTH - 1));
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {in_range_r, written_r};
  assign out_tdata  = out_cell_r;

  `TCDC_ASSERT_NEXT(a_valid_from_finish, clk, rst_n, !out_valid_r && !cmd.finish, !out_valid_r)
  `TCDC_ASSERT_SAME(a_write_on_screen, clk, rst_n, item_we, hit_r && !cmd.sweep)
  `TCDC_ASSERT_SAME(a_sweep_no_finish, clk, rst_n, cmd.sweep, !cmd.finish)

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the character cell depth compositor. Draw, read,
// clear and undefined beats go in over a sequence of screen sizes; a cell
// frame model predicts every result beat, and results are checked in order.
// Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
  import tcdc_pkg::*;

  localparam int          STORE_DEPTH  = DEF_MAX_COLUMNS * DEF_MAX_ROWS;
  localparam logic [1:0]  KIND_UNDEF   = 2'd3;
  localparam int          LIMIT_CYCLES = 3_000_000;

  // packed so that row sits in the lowest bits of in_tdata
  typedef struct packed {
    logic [3:0]         pad;
    logic signed [31:0] priority_req;
    logic [15:0]        color;
    logic [7:0]         glyph;
    logic [11:0]        char_offset;
    logic signed [15:0] start_x;
    logic signed [15:0] row;
  } glyph_beat_t;

  typedef struct {
    logic  written;
    logic  in_range;
    cell_t cell_val;
  } cell_result_t;

  class cell_frame_model;
    cell_t        frame [STORE_DEPTH];
    int unsigned  cols_reg;
    int unsigned  rows_reg;
    cell_result_t pending_cells [$];
    int unsigned  errors;

    function new();
      cols_reg = RST_SCREEN_WIDTH;
      rows_reg = RST_SCREEN_HEIGHT;
      errors   = 0;
      blank_frame();
    endfunction

    function void blank_frame();
      foreach (frame[i]) frame[i] = BLANK_CELL;
    endfunction

    function void write_reg(logic idx, logic [8:0] data);
      if (idx == CFG_WIDTH) cols_reg = data;
      else rows_reg = data[7:0];
    endfunction

    function bit find_cell(int r, int c, output int slot);
      int w;
      int h;
      w = (cols_reg > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : cols_reg;
      h = (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_reg;
      slot = 0;
      if (r < 0 || c < 0) return 0;
      if (r >= h || c >= w) return 0;
      slot = r * w + c;
      return slot < STORE_DEPTH;
    endfunction

    function void accept_item(logic [1:0] kind, glyph_beat_t b);
      cell_result_t res;
      int r;
      int sx;
      int off;
      int slot;
      res.written  = 1'b0;
      res.in_range = 1'b0;
      res.cell_val = '0;
      r   = b.row;
      sx  = b.start_x;
      off = b.char_offset;
      case (kind)
        KIND_DRAW: begin
          if (find_cell(r, sx + off, slot)) begin
            res.in_range = 1'b1;
            if ($signed(frame[slot].prio) <= b.priority_req) begin
              frame[slot].glyph = b.glyph;
              frame[slot].color = b.color;
              frame[slot].prio  = b.priority_req;
              res.written = 1'b1;
            end
          end
        end
        KIND_READ: begin
          if (find_cell(r, sx, slot)) begin
            res.in_range = 1'b1;
            res.cell_val = frame[slot];
          end
        end
        KIND_CLEAR: blank_frame();
        default: ;
      endcase
      pending_cells.push_back(res);
    endfunction

    function void report(string what, logic [31:0] exp, logic [31:0] act);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp, act);
    endfunction

    function void match_result(logic [1:0] flags, cell_t got);
      cell_result_t exp;
      if (pending_cells.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h/%h",
                 $time, flags, got);
        return;
      end
      exp = pending_cells.pop_front();
      if (flags[0] !== exp.written)
        report("written", exp.written, flags[0]);
      if (flags[1] !== exp.in_range)
        report("in_range", exp.in_range, flags[1]);
      if (got.glyph !== exp.cell_val.glyph)
        report("cell_glyph", exp.cell_val.glyph, got.glyph);
      if (got.color !== exp.cell_val.color)
        report("cell_color", exp.cell_val.color, got.color);
      if (got.prio !== exp.cell_val.prio)
        report("cell_priority", exp.cell_val.prio, got.prio);
    endfunction

    function int outstanding();
      return pending_cells.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic         cfg_index  = 1'b0;
  logic [8:0]   cfg_data   = '0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser   = '0;
  logic [103:0] in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [1:0]   out_tuser;
  logic [55:0]  out_tdata;

  cell_frame_model cells = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     stall_pct     = 0;
  int unsigned     cur_w         = RST_SCREEN_WIDTH;
  int unsigned     cur_h         = RST_SCREEN_HEIGHT;
  int unsigned     cycle_count   = 0;

  text_cell_depth_compositor_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) cells.write_reg(cfg_index, cfg_data);
      if (out_tvalid && out_tready) cells.match_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready) cells.accept_item(in_tuser, in_tdata);
    end
  end

  function automatic glyph_beat_t mk_beat(int r, int sx, int off, int g, int color, int prio);
    glyph_beat_t b;
    b              = '0;
    b.row          = 16'(r);
    b.start_x      = 16'(sx);
    b.char_offset  = 12'(off);
    b.glyph        = 8'(g);
    b.color        = 16'(color);
    b.priority_req = prio;
    return b;
  endfunction

  function automatic glyph_beat_t random_beat(logic [1:0] kind);
    glyph_beat_t b;
    int w;
    int h;
    int r;
    int c;
    int off;
    w = (cur_w > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : cur_w;
    h = (cur_h > DEF_MAX_ROWS) ? DEF_MAX_ROWS : cur_h;
    b = '0;
    b.glyph = 8'($urandom);
    b.color = 16'($urandom);
    off = $urandom_range(0, 7);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        b.row          = 16'($urandom);
        b.start_x      = 16'($urandom);
        b.char_offset  = 12'($urandom);
        b.priority_req = $urandom;
        return b;
      end
      3, 4, 5: begin
        r = $urandom_range(0, 2);
        c = $urandom_range(0, 5);
      end
      default: begin
        r = $urandom_range(0, h);
        c = $urandom_range(0, w);
      end
    endcase
    if (kind == KIND_READ) off = 0;
    b.row         = 16'(r);
    b.start_x     = 16'(c - off);
    b.char_offset = 12'(off);
    if ($urandom_range(0, 1)) b.priority_req = $urandom_range(0, 8) - 4;
    else b.priority_req = $urandom;
    return b;
  endfunction

  task automatic cfg_write(logic idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH) cur_w = data;
    else cur_h = data[7:0];
    @(negedge clk);
  endtask

  task automatic send_beat(logic [1:0] kind, glyph_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (cells.outstanding() != 0) @(negedge clk);
  endtask

  task automatic random_items(int count);
    int          pick;
    logic [1:0]  kind;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 56) kind = KIND_DRAW;
      else if (pick < 95) kind = KIND_READ;
      else if (pick < 98) kind = KIND_UNDEF;
      else kind = KIND_CLEAR;
      send_beat(kind, random_beat(kind));
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  initial begin
    int unsigned widths  [6] = '{256, 1, 511, 0, 37, 300};
    int unsigned heights [6] = '{128, 1, 255, 7, 0, 200};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default 80x25 screen, blank frame
    send_beat(KIND_READ,  mk_beat(0, 0, 0, 0, 0, 0));
    send_beat(KIND_DRAW,  mk_beat(0, 0, 0, 8'h41, 16'hFFFF, -1));
    send_beat(KIND_DRAW,  mk_beat(0, 0, 0, 8'h42, 16'h1234, -2));
    send_beat(KIND_READ,  mk_beat(0, 0, 0, 0, 0, 0));
    send_beat(KIND_DRAW,  mk_beat(24, 70, 9, 8'hFF, 16'h8001, 32'h7FFF_FFFF));
    send_beat(KIND_DRAW,  mk_beat(24, 70, 10, 8'h43, 16'h0001, 5));
    send_beat(KIND_DRAW,  mk_beat(25, 0, 0, 8'h44, 16'h0002, 5));
    send_beat(KIND_DRAW,  mk_beat(-1, 0, 0, 8'h45, 16'h0003, 5));
    send_beat(KIND_DRAW,  mk_beat(-32768, 32767, 4095, 8'h46, 16'h0004, 5));
    send_beat(KIND_DRAW,  mk_beat(1, -5, 5, 8'h47, 16'hA5A5, 0));
    send_beat(KIND_DRAW,  mk_beat(2, 3, 0, 8'h00, 16'h0000, 32'h8000_0000));
    send_beat(KIND_READ,  mk_beat(24, 79, 0, 0, 0, 0));
    send_beat(KIND_READ,  mk_beat(1, 0, 7, 0, 0, 0));
    send_beat(KIND_READ,  mk_beat(2, 3, 0, 0, 0, 0));
    send_beat(KIND_READ,  mk_beat(0, -1, 0, 0, 0, 0));
    send_beat(KIND_READ,  mk_beat(32767, 0, 0, 0, 0, 0));
    send_beat(KIND_UNDEF, mk_beat(0, 0, 0, 8'h55, 16'h5555, 7));
    send_beat(KIND_READ,  mk_beat(0, 0, 0, 0, 0, 0));
    send_beat(KIND_CLEAR, mk_beat(0, 0, 0, 0, 0, 0));
    send_beat(KIND_READ,  mk_beat(0, 0, 0, 0, 0, 0));
    send_beat(KIND_READ,  mk_beat(24, 79, 0, 0, 0, 0));
    send_beat(KIND_DRAW,  mk_beat(0, 0, 0, 8'hFF, 16'h0000, 0));
    send_beat(KIND_READ,  mk_beat(0, 0, 0, 0, 0, 0));
    random_items(55);
    drain();

    for (int p = 1; p <= 6; p++) begin
      cfg_write(CFG_WIDTH, 9'(widths[p-1]));
      cfg_write(CFG_HEIGHT, {1'($urandom_range(0, 1)), 8'(heights[p-1])});
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      random_items(55);
      drain();
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (16) @(negedge clk);
    if (cells.errors == 0 && cells.outstanding() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* text_cell_depth_compositor_unit.f */
+incdir+rtl
rtl/tcdc_pkg.sv
rtl/tcdc_ctrl.sv
rtl/tcdc_datapath.sv
rtl/text_cell_depth_compositor_unit.sv
verif/tb_top.sv
